// ----- rtl/core/anxb_pkg.sv -----
// Shared types and constants for the Annex B NAL splitter.
// Used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package anxb_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned WINDOW_LEN  = 4;
   localparam int unsigned HELD_MAX    = 3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       nal_first;
      logic       packet_done;
      logic       run_last;
   } rsp_payload_type;

   // Results caused by one input item, packed from slot 0 up.
   typedef struct packed {
      logic [WINDOW_LEN-1:0][7:0] bytes;
      logic [WINDOW_LEN-1:0]      first;
      logic [1:0]                 last_idx;
      logic                       pkt_end;
   } nal_entry_type;

   typedef struct packed {
      logic          valid;
      nal_entry_type entry;
   } queue_slot_type;

endpackage

`default_nettype wire

// ----- rtl/core/anxb_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
// Payload types come from anxb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface anxb_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/anxb_front.sv -----
// Front end: lookahead store and start-code judging, at most one entry per item.
// Depends on anxb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module anxb_front
   import anxb_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire req_payload_type req_payload,
   output logic                 req_ready,
   input  wire logic            queue_full,
   output queue_slot_type       push
);

   logic [7:0] look_ff [0:HELD_MAX-1];
   logic [7:0] look_in [0:HELD_MAX-1];
   logic [1:0] held_ff, held_in;
   logic       inside_ff, inside_in;
   logic [1:0] code_left_ff, code_left_in;

   logic [7:0]    win [0:2*WINDOW_LEN-2];
   logic [2:0]    n_known;
   logic [2:0]    judge_cnt;
   logic [2:0]    k_known;
   logic [2:0]    res_cnt;
   logic [1:0]    cl;
   logic          ins;
   logic          emit;
   logic          is_first;
   logic          accept;
   nal_entry_type entry;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      for (int i = 0; i < 2*WINDOW_LEN-1; i++) begin
         win[i] = 8'd0;
      end
      for (int i = 0; i < HELD_MAX; i++) begin
         if (2'(i) < held_ff) begin
            win[i] = look_ff[i];
         end
      end
      win[{1'b0, held_ff}] = req_payload.data_byte;
      n_known   = {1'b0, held_ff} + 3'd1;
      judge_cnt = req_payload.packet_end ? n_known :
                  ((held_ff == 2'(HELD_MAX)) ? 3'd1 : 3'd0);

      cl       = code_left_ff;
      ins      = inside_ff;
      res_cnt  = 3'd0;
      entry    = '0;
      k_known  = 3'd0;
      emit     = 1'b0;
      is_first = 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         k_known = req_payload.packet_end ? (n_known - 3'(i)) : 3'(WINDOW_LEN);
         if (3'(i) < judge_cnt) begin
            emit     = 1'b0;
            is_first = 1'b0;
            if (cl != 2'd0) begin
               emit = 1'b1;
               cl   = cl - 2'd1;
            end else if (k_known >= 3'd4 && win[i] == 8'd0 && win[i+1] == 8'd0 &&
                         win[i+2] == 8'd0 && win[i+3] == 8'd1) begin
               emit     = 1'b1;
               is_first = 1'b1;
               ins      = 1'b1;
               cl       = 2'd3;
            end else if (k_known >= 3'd3 && win[i] == 8'd0 && win[i+1] == 8'd0 &&
                         win[i+2] == 8'd1) begin
               emit     = 1'b1;
               is_first = 1'b1;
               ins      = 1'b1;
               cl       = 2'd2;
            end else begin
               emit = ins;
            end
            if (emit) begin
               entry.bytes[res_cnt[1:0]] = win[i];
               entry.first[res_cnt[1:0]] = is_first;
               res_cnt                   = res_cnt + 3'd1;
            end
         end
      end
      entry.last_idx = res_cnt[1:0] - 2'd1;
      entry.pkt_end  = req_payload.packet_end;
   end

   assign push.valid = accept && (res_cnt != 3'd0);
   assign push.entry = entry;

   always_comb begin
      look_in      = look_ff;
      held_in      = held_ff;
      inside_in    = inside_ff;
      code_left_in = code_left_ff;
      if (accept) begin
         if (req_payload.packet_end) begin
            for (int i = 0; i < HELD_MAX; i++) begin
               look_in[i] = 8'd0;
            end
            held_in      = 2'd0;
            inside_in    = 1'b0;
            code_left_in = 2'd0;
         end else if (held_ff != 2'(HELD_MAX)) begin
            look_in[held_ff] = req_payload.data_byte;
            held_in          = held_ff + 2'd1;
         end else begin
            for (int i = 0; i < HELD_MAX; i++) begin
               look_in[i] = win[i+1];
            end
            inside_in    = ins;
            code_left_in = cl;
         end
      end
   end

   always_ff @(posedge clock) begin
      look_ff <= look_in;
      if (reset) begin
         held_ff      <= 2'd0;
         inside_ff    <= 1'b0;
         code_left_ff <= 2'd0;
      end else begin
         held_ff      <= held_in;
         inside_ff    <= inside_in;
         code_left_ff <= code_left_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/anxb_queue.sv -----
// Short register queue of result entries between front and back end.
// Depends on anxb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module anxb_queue
   import anxb_pkg::*;
#(
   parameter int unsigned Depth = QUEUE_DEPTH
)(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_slot_type push,
   input  wire logic           pop,
   output logic                full,
   output queue_slot_type      head
);

   localparam int unsigned PtrW = $clog2(Depth);
   localparam int unsigned CntW = $clog2(Depth + 1);

   nal_entry_type    slot_ff [0:Depth-1];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/anxb_back.sv -----
// Back end: walks the head entry one result per transfer.
// Depends on anxb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module anxb_back
   import anxb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_slot_type head,
   output logic                pop,
   output logic                rsp_valid,
   output rsp_payload_type     rsp_payload,
   input  wire logic           rsp_ready
);

   logic [1:0] idx_ff, idx_in;
   logic       at_last;

   assign at_last   = (idx_ff == head.entry.last_idx);
   assign rsp_valid = head.valid;
   assign pop       = head.valid && rsp_ready && at_last;

   assign rsp_payload.out_byte    = head.entry.bytes[idx_ff];
   assign rsp_payload.nal_first   = head.entry.first[idx_ff];
   assign rsp_payload.packet_done = at_last && head.entry.pkt_end;
   assign rsp_payload.run_last    = at_last;

   always_comb begin
      idx_in = idx_ff;
      if (head.valid && rsp_ready) begin
         idx_in = at_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/annexb_nal_splitter.sv -----
// Top level of the Annex B NAL splitter: front end, result queue, back end.
// Depends on anxb_pkg, anxb_stream_if, anxb_front, anxb_queue, anxb_back.
//
//   channel    dir  payload                                         handshake
//   req_chan   in   data_byte[7:0], packet_end                      valid/ready
//   rsp_chan   out  out_byte[7:0], nal_first, packet_done, run_last valid/ready
//
// One byte is taken per cycle while the result queue has room.
// Results are registered in the result queue before they show on rsp_chan.
// A packet-end byte gives up to four results, one per cycle from the back end while rsp_chan is ready.
// Synchronous reset clears lookahead fill and start-code state, queue pointers and back-end index.
// Output stalls fill the queue; req_chan.ready drops only when it is full.
`timescale 1ns / 1ps
`default_nettype none

module annexb_nal_splitter
   import anxb_pkg::*;
#(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
)(
   input  wire logic     clock,
   input  wire logic     reset,
   anxb_stream_if.sink   req_chan,
   anxb_stream_if.source rsp_chan
);

   queue_slot_type  push;
   queue_slot_type  head;
   logic            queue_full;
   logic            pop;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;

   assign req_payload      = req_chan.payload;
   assign rsp_chan.payload = rsp_payload;

   anxb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_payload (req_payload),
      .req_ready   (req_chan.ready),
      .queue_full  (queue_full),
      .push        (push)
   );

   anxb_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   anxb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_chan.valid),
      .rsp_payload (rsp_payload),
      .rsp_ready   (rsp_chan.ready)
   );

endmodule

`default_nettype wire
